// ----- design/smf_pkg.sv -----
// Shared constants and types for the sliding median filter.
// Used by the cell chain and the top level; depends on nothing else.
package smf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration register file.
    localparam int WSIZE_BITS    = 6;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 6'd5;
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Operation applied to the sorted chain at the next clock edge.
    typedef struct packed {
        logic ins;
        logic rem;
        logic clear;
    } t_chain_cmd;

endpackage

// ----- design/sliding_median_filter_top.sv -----
// An item that fills the lag, or a last item, sends the FSM to ST_EMIT, where its
// results are registered one by one; o_s_tready is low there, so no new item is taken
// until they are out. A last item flushes its results through the single sorted chain.
// Results wait in an output register while the next item is taken.
// Reset (i_rst_n low, synchronous) empties the window, sets window_size to 5, clears
// the output; stored samples are not cleared.
module sliding_median_filter_top #(
    parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [DATA_BITS-1:0]                i_s_tdata,   // sample
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [DATA_BITS-1:0]                o_m_tdata,   // filtered
    output logic                                o_m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [smf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [smf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import smf_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int WW = (CW > WSIZE_BITS) ? CW : WSIZE_BITS;

    t_state                        r_state;
    t_state                        n_state;
    logic [WSIZE_BITS-1:0]         r_wsize;
    logic [AW-1:0]                 r_lag;
    logic [AW-1:0]                 r_c;
    logic                          r_flush;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_data;
    logic                          r_out_last;

    logic [WW-1:0]                 wsize_ext;
    logic [CW-1:0]                 win_n;
    logic [AW-1:0]                 win_nl;
    logic [AW-1:0]                 win_nr;
    logic                          cfg_wr;
    logic                          accept;
    logic                          lag_full;
    logic                          out_free;
    logic [CW-1:0]                 limit;
    logic                          trim;
    logic                          emit;
    logic                          done;
    t_chain_cmd                    cmd;
    logic [CW-1:0]                 count;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] median;

    // Effective window: zero acts as one, oversize values clamp to the chain length.
    always_comb begin
        wsize_ext = WW'(r_wsize);
        if (wsize_ext == '0) begin
            win_n = CW'(1);
        end else if (wsize_ext > WW'(MAX_WINDOW)) begin
            win_n = CW'(MAX_WINDOW);
        end else begin
            win_n = CW'(wsize_ext);
        end
        win_nl = AW'(win_n >> 1);
        win_nr = AW'(win_n - (win_n >> 1) - CW'(1));
    end

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_BITS-1] == REG_WINDOW_SIZE);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_BITS-1] == REG_WINDOW_SIZE)
                    ? APB_DATA_BITS'(r_wsize) : '0;

    assign sample     = signed'(i_s_tdata[SAMPLE_BITS-1:0]);
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign lag_full   = (r_lag >= win_nr);
    assign out_free   = !r_out_valid || i_m_tready;

    // The window centered c samples back holds at most c + n_left + 1 samples;
    // during a flush the oldest one drops out before each result.
    assign limit = CW'(r_c) + CW'(win_nl) + CW'(1);
    assign trim  = (count > limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_tlast || lag_full)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        done      = 1'b0;
        cmd.ins   = 1'b0;
        cmd.rem   = 1'b0;
        cmd.clear = cfg_wr;
        case (r_state)
            ST_IDLE: begin
                cmd.ins = accept;
                cmd.rem = accept && (count == win_n);
            end
            ST_EMIT: begin
                cmd.rem   = trim;
                emit      = !trim && out_free;
                done      = emit && (!r_flush || (r_c == '0));
                cmd.clear = done && r_flush;
            end
            default: begin
                cmd.clear = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wsize     <= WSIZE_RESET;
            r_lag       <= '0;
            r_c         <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_wsize <= pwdata[WSIZE_BITS-1:0];
                r_lag   <= '0;
            end
            if (accept) begin
                r_flush <= i_s_tlast;
                if (i_s_tlast) begin
                    r_c   <= lag_full ? win_nr : r_lag;
                    r_lag <= '0;
                end else begin
                    r_c   <= win_nr;
                    r_lag <= lag_full ? win_nr : r_lag + AW'(1);
                end
            end else if (emit && !done) begin
                r_c <= r_c - AW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_last  <= r_flush && (r_c == '0);
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= unsigned'(median);
        end
    end

    smf_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_x      (sample),
        .o_count  (count),
        .o_median (median)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_BITS'(r_out_data);
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= win_n)
        else $error("chain holds more samples than the window");

    a_emit_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (count != '0))
        else $error("median requested from an empty chain");

    a_steady_no_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_flush) |-> !trim)
        else $error("steady-state result needs a trim");
`endif

endmodule

// ----- design/smf_cell.sv -----
// One cell of the sorted sample chain: holds a sample and its age.
// Depends on nothing; instantiated in a row by smf_chain.
module smf_cell #(
    parameter int SAMPLE_BITS = 24,
    parameter int AGE_BITS    = 5
) (
    input  logic                          i_clk,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic                          i_ins,
    input  logic                          i_rem,
    input  logic [AGE_BITS-1:0]           i_rem_age,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_v_prev,
    input  logic [AGE_BITS-1:0]           i_age_prev,
    input  logic                          i_lt_prev,
    input  logic                          i_rb_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_v_next,
    input  logic [AGE_BITS-1:0]           i_age_next,
    input  logic                          i_g_next,
    input  logic                          i_sel_a,
    input  logic                          i_sel_b,
    output logic signed [SAMPLE_BITS-1:0] o_v,
    output logic [AGE_BITS-1:0]           o_age,
    output logic                          o_g,
    output logic                          o_lt,
    output logic                          o_rb,
    output logic                          o_hit,
    output logic signed [SAMPLE_BITS-1:0] o_tap_a,
    output logic signed [SAMPLE_BITS-1:0] o_tap_b
);
    logic signed [SAMPLE_BITS-1:0] r_v;
    logic signed [SAMPLE_BITS-1:0] n_v;
    logic [AGE_BITS-1:0]           r_age;
    logic [AGE_BITS-1:0]           n_age;
    logic [AGE_BITS-1:0]           keep_age;
    logic                          g;
    logic                          hit;
    logic                          rb;
    logic                          lt;
    logic                          eq;

    // An empty cell counts as larger than any new sample.
    assign g   = !i_valid || (r_v > i_x);
    assign hit = i_rem && i_valid && (r_age == i_rem_age);
    assign rb  = i_rb_prev || hit;
    // lt: this slot keeps an old sample below the insertion point.
    assign lt  = !i_ins || (rb ? !i_g_next : !g);
    assign eq  = i_ins && !lt && i_lt_prev;

    always_comb begin
        keep_age = r_age;
        n_v      = r_v;
        if (lt) begin
            if (rb) begin
                n_v      = i_v_next;
                keep_age = i_age_next;
            end
        end else if (eq) begin
            n_v      = i_x;
            keep_age = '0;
        end else if (!i_rb_prev) begin
            n_v      = i_v_prev;
            keep_age = i_age_prev;
        end
        n_age = eq ? '0 : keep_age + AGE_BITS'(i_ins);
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_age <= n_age;
    end

    assign o_v     = r_v;
    assign o_age   = r_age;
    assign o_g     = g;
    assign o_lt    = lt;
    assign o_rb    = rb;
    assign o_hit   = hit;
    assign o_tap_a = i_sel_a ? r_v : '0;
    assign o_tap_b = i_sel_b ? r_v : '0;

endmodule

// ----- design/smf_chain.sv -----
// Row of smf_cell instances that keeps the current window sorted, plus the
// fill count and the median pick. Depends on smf_pkg and smf_cell.
module smf_chain #(
    parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
    localparam int AW = $clog2(MAX_WINDOW),
    localparam int CW = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smf_pkg::t_chain_cmd           i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic [CW-1:0]                 o_count,
    output logic signed [SAMPLE_BITS-1:0] o_median
);
    import smf_pkg::*;

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [AW-1:0]                 rem_age;
    logic [AW-1:0]                 mid;
    logic                          odd;
    logic                          valid [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] v     [MAX_WINDOW];
    logic [AW-1:0]                 age   [MAX_WINDOW];
    logic                          g     [MAX_WINDOW];
    logic                          lt    [MAX_WINDOW];
    logic                          rb    [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         hit;
    logic                          sel_a [MAX_WINDOW];
    logic                          sel_b [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] tap_a [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] tap_b [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] med_a;
    logic signed [SAMPLE_BITS-1:0] med_b;
    logic signed [SAMPLE_BITS:0]   med_sum;

    // The oldest sample in the window always carries the largest age.
    assign rem_age = AW'(r_count - CW'(1));
    assign mid     = AW'(r_count >> 1);
    assign odd     = r_count[0];

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] v_prev;
        logic [AW-1:0]                 age_prev;
        logic                          lt_prev;
        logic                          rb_prev;
        logic signed [SAMPLE_BITS-1:0] v_next;
        logic [AW-1:0]                 age_next;
        logic                          g_next;

        if (i == 0) begin : g_head
            assign v_prev   = v[i];
            assign age_prev = age[i];
            assign lt_prev  = 1'b1;
            assign rb_prev  = 1'b0;
        end else begin : g_body
            assign v_prev   = v[i-1];
            assign age_prev = age[i-1];
            assign lt_prev  = lt[i-1];
            assign rb_prev  = rb[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_tail
            assign v_next   = v[i];
            assign age_next = age[i];
            assign g_next   = 1'b1;
        end else begin : g_inner
            assign v_next   = v[i+1];
            assign age_next = age[i+1];
            assign g_next   = g[i+1];
        end

        assign valid[i] = (CW'(i) < r_count);
        assign sel_a[i] = (AW'(i) == mid);
        assign sel_b[i] = odd ? sel_a[i] : (AW'(i + 1) == mid);

        smf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_BITS    (AW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_x        (i_x),
            .i_ins      (i_cmd.ins),
            .i_rem      (i_cmd.rem),
            .i_rem_age  (rem_age),
            .i_valid    (valid[i]),
            .i_v_prev   (v_prev),
            .i_age_prev (age_prev),
            .i_lt_prev  (lt_prev),
            .i_rb_prev  (rb_prev),
            .i_v_next   (v_next),
            .i_age_next (age_next),
            .i_g_next   (g_next),
            .i_sel_a    (sel_a[i]),
            .i_sel_b    (sel_b[i]),
            .o_v        (v[i]),
            .o_age      (age[i]),
            .o_g        (g[i]),
            .o_lt       (lt[i]),
            .o_rb       (rb[i]),
            .o_hit      (hit[i]),
            .o_tap_a    (tap_a[i]),
            .o_tap_b    (tap_b[i])
        );
    end

    // For an odd count both taps pick the middle cell, so one formula serves.
    always_comb begin
        med_a = '0;
        med_b = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            med_a = med_a | tap_a[k];
            med_b = med_b | tap_b[k];
        end
        med_sum = {med_a[SAMPLE_BITS-1], med_a} + {med_b[SAMPLE_BITS-1], med_b};
    end

    assign o_median = med_sum[SAMPLE_BITS:1];

    always_comb begin
        if (i_cmd.clear) begin
            n_count = '0;
        end else begin
            n_count = r_count + CW'(i_cmd.ins) - CW'(i_cmd.rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

`ifndef NO_ASSERTIONS
    for (genvar j = 0; j < MAX_WINDOW - 1; j++) begin : g_sorted_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            valid[j+1] |-> (v[j] <= v[j+1]))
            else $error("sorted chain out of order");
    end

    a_one_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem |-> $onehot(hit))
        else $error("removal does not match exactly one cell");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && !i_cmd.rem && !i_cmd.clear) |-> (r_count < CW'(MAX_WINDOW)))
        else $error("insert into a full chain");
`endif

endmodule
